// ----- rtl/bmp24_to_framebuffer_writer_assert.svh -----
// assertion macros shared by the checker
`ifndef BMP24_TO_FRAMEBUFFER_WRITER_ASSERT_SVH
`define BMP24_TO_FRAMEBUFFER_WRITER_ASSERT_SVH

// antecedent holds in this cycle, consequent in the same cycle
`define BMP24FB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bmp24fb: same-cycle check failed");

// antecedent holds in this cycle, consequent in the next one
`define BMP24FB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bmp24fb: next-cycle check failed");

`endif

// ----- rtl/bmp24fb_pkg.sv -----
package bmp24fb_pkg;

  localparam int unsigned ScreenWidthDef  = 800;
  localparam int unsigned ScreenHeightDef = 480;
  localparam int unsigned HeaderBytesDef  = 54;

  localparam int unsigned WidthW  = 10;
  localparam int unsigned HeightW = 9;
  localparam int unsigned IndexW  = 19;
  localparam int unsigned CfgW    = 10;
  localparam int unsigned HdrW    = 6;

  localparam logic [WidthW-1:0]  WidthRst  = WidthW'(800);
  localparam logic [HeightW-1:0] HeightRst = HeightW'(480);

  typedef enum logic [1:0] {
    REG_WIDTH   = 2'd0,
    REG_HEIGHT  = 2'd1,
    REG_PLACE_X = 2'd2,
    REG_PLACE_Y = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_BLUE  = 3'b001,
    PH_GREEN = 3'b010,
    PH_RED   = 3'b100
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } in_item_t;

  typedef struct packed {
    logic [IndexW-1:0] screen_index;
    logic [23:0]       pixel_word;
    logic              last_pixel;
    logic              too_big;
  } out_item_t;

  typedef struct packed {
    logic [WidthW-1:0]  image_width;
    logic [HeightW-1:0] image_height;
    logic [WidthW-1:0]  place_x;
    logic [HeightW-1:0] place_y;
  } cfg_t;

  // one assembled pixel with its clamped file position
  typedef struct packed {
    logic [23:0]        word;
    logic [WidthW-1:0]  col;
    logic [HeightW-1:0] row;
    logic               last;
  } pix_t;

  function automatic logic [WidthW-1:0] width_m1(input logic [WidthW-1:0] w);
    return (w == '0) ? '0 : w - WidthW'(1);
  endfunction

  function automatic logic [HeightW-1:0] height_m1(input logic [HeightW-1:0] h);
    return (h == '0) ? '0 : h - HeightW'(1);
  endfunction

endpackage

// ----- rtl/bmp24fb_parse.sv -----
module bmp24fb_parse import bmp24fb_pkg::*; #(
  parameter int unsigned HEADER_BYTES = HeaderBytesDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  output logic     pix_valid_o,
  input  logic     pix_ready_i,
  output pix_t     pix_o
);

  localparam logic [HdrW-1:0] HdrRst = HdrW'(HEADER_BYTES);

  logic [HdrW-1:0]    hdr_q, hdr_d;
  phase_e             phase_q, phase_d;
  logic [WidthW-1:0]  col_q, col_d;
  logic [HeightW-1:0] row_q, row_d;
  logic [1:0]         pad_q, pad_d;
  logic [15:0]        part_q, part_d;
  logic               done_q, done_d;

  logic               pix_valid_q;
  pix_t               pix_q, pix_d;
  logic               emit;

  logic [WidthW-1:0]  wm1;
  logic [HeightW-1:0] hm1;
  logic [1:0]         row_pad;
  logic               row_end, last;
  logic               accept;

  assign wm1     = width_m1(cfg_i.image_width);
  assign hm1     = height_m1(cfg_i.image_height);
  // padding to a multiple of four is (-3w) mod 4, which is w mod 4
  assign row_pad = (cfg_i.image_width == '0) ? 2'd1 : cfg_i.image_width[1:0];

  assign in_ready_o  = !pix_valid_q || pix_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign pix_valid_o = pix_valid_q;
  assign pix_o       = pix_q;

  always_comb begin
    hdr_d   = hdr_q;
    phase_d = phase_q;
    col_d   = col_q;
    row_d   = row_q;
    pad_d   = pad_q;
    part_d  = part_q;
    done_d  = done_q;
    emit    = 1'b0;
    row_end = 1'b0;
    last    = 1'b0;
    pix_d   = pix_q;

    if (in_data_i.file_start) begin
      hdr_d   = HdrRst;
      phase_d = PH_BLUE;
      col_d   = '0;
      row_d   = '0;
      pad_d   = '0;
      part_d  = '0;
      done_d  = 1'b0;
    end

    if (done_d) begin
      // image finished, wait for a new file
    end else if (hdr_d != '0) begin
      hdr_d = hdr_d - HdrW'(1);
    end else if (pad_d != '0) begin
      pad_d = pad_d - 2'd1;
    end else begin
      case (phase_d)
        PH_BLUE: begin
          part_d  = {8'h00, in_data_i.data_byte};
          phase_d = PH_GREEN;
        end
        PH_GREEN: begin
          part_d[15:8] = in_data_i.data_byte;
          phase_d      = PH_RED;
        end
        default: begin
          emit       = 1'b1;
          row_end    = (col_d >= wm1);
          last       = row_end && (row_d >= hm1);
          pix_d.word = {in_data_i.data_byte, part_d};
          pix_d.col  = (col_d < wm1) ? col_d : wm1;
          pix_d.row  = (row_d < hm1) ? row_d : hm1;
          pix_d.last = last;
          phase_d    = PH_BLUE;
          part_d     = '0;
          if (row_end) begin
            col_d = '0;
            row_d = row_d + HeightW'(1);
            pad_d = row_pad;
          end else begin
            col_d = col_d + WidthW'(1);
          end
          if (last) begin
            done_d = 1'b1;
            pad_d  = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q       <= HdrRst;
      phase_q     <= PH_BLUE;
      col_q       <= '0;
      row_q       <= '0;
      pad_q       <= '0;
      part_q      <= '0;
      done_q      <= 1'b0;
      pix_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        hdr_q   <= hdr_d;
        phase_q <= phase_d;
        col_q   <= col_d;
        row_q   <= row_d;
        pad_q   <= pad_d;
        part_q  <= part_d;
        done_q  <= done_d;
      end
      if (in_ready_o) begin
        pix_valid_q <= accept && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      pix_q <= pix_d;
    end
  end

endmodule

// ----- rtl/bmp24fb_index.sv -----
module bmp24fb_index import bmp24fb_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = ScreenWidthDef,
  parameter int unsigned SCREEN_HEIGHT = ScreenHeightDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      pix_valid_i,
  output logic      pix_ready_o,
  input  pix_t      pix_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned SwW    = $clog2(SCREEN_WIDTH + 1);
  localparam int unsigned ShW    = $clog2(SCREEN_HEIGHT + 1);
  localparam int unsigned XCmpW  = ((SwW > WidthW) ? SwW : WidthW) + 1;
  localparam int unsigned YCmpW  = ((ShW > HeightW) ? ShW : HeightW) + 1;
  localparam int unsigned ProdRw = WidthW + SwW + 1;
  localparam int unsigned ProdW  = (ProdRw > IndexW) ? ProdRw : IndexW;

  logic [XCmpW-1:0]   x_end;
  logic [YCmpW-1:0]   y_end;
  logic               big;
  logic [WidthW-1:0]  w_eff;
  logic [HeightW-1:0] h_eff;
  logic [HeightW-1:0] hm1;
  logic [WidthW-1:0]  scr_row;
  logic [ProdW-1:0]   lin;
  logic               out_valid_q;
  out_item_t          out_q;
  logic               accept;

  assign w_eff = (cfg_i.image_width == '0) ? WidthW'(1) : cfg_i.image_width;
  assign h_eff = (cfg_i.image_height == '0) ? HeightW'(1) : cfg_i.image_height;
  assign hm1   = height_m1(cfg_i.image_height);

  assign x_end = XCmpW'(cfg_i.place_x) + XCmpW'(w_eff);
  assign y_end = YCmpW'(cfg_i.place_y) + YCmpW'(h_eff);
  assign big   = (x_end > XCmpW'(SCREEN_WIDTH)) || (y_end > YCmpW'(SCREEN_HEIGHT));

  // file rows run bottom-up, row is already clamped to height - 1
  assign scr_row = WidthW'(cfg_i.place_y) + WidthW'(hm1) - WidthW'(pix_i.row);
  assign lin     = ProdW'(scr_row) * ProdW'(SCREEN_WIDTH)
                 + ProdW'(cfg_i.place_x) + ProdW'(pix_i.col);

  assign pix_ready_o = !out_valid_q || out_ready_i;
  assign accept      = pix_valid_i && pix_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pix_ready_o) begin
      out_valid_q <= pix_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q.screen_index <= big ? '0 : lin[IndexW-1:0];
      out_q.pixel_word   <= pix_i.word;
      out_q.last_pixel   <= pix_i.last;
      out_q.too_big      <= big;
    end
  end

endmodule

// ----- rtl/bmp24_to_framebuffer_writer.sv -----
// 24-bit bitmap byte stream to framebuffer pixel writes.
// in channel: one file byte per word (data_byte, file_start), valid/ready.
// file_start on a byte clears all counters and treats it as the file's first byte.
// the header bytes and each row's padding give no output word; the third byte
// of every pixel gives one out word with the pixel and its framebuffer index.
// the accepted third byte goes through the pixel register, then the index register.
// throughput: one byte per clock unless out_ready_i stalls the output, set by the two
// register stages (pixel assembly, then index multiply-add) which each take a new word
// every cycle. cfg channel: width, height, place x, place y by index; always ready; the
// user must write it only while the block is idle; the block itself does not enforce it.
// reset: registers go to 800x480 at 0,0 and the parser waits for the header.
// when out_ready_i is low the output word holds, the middle stage fills, then
// in_ready_o drops; no word is lost or repeated.
// too_big flags every pixel of an image that does not fit the screen; its index is 0.
module bmp24_to_framebuffer_writer import bmp24fb_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = ScreenWidthDef,
  parameter int unsigned SCREEN_HEIGHT = ScreenHeightDef,
  parameter int unsigned HEADER_BYTES  = HeaderBytesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_index_i,
  input  logic [CfgW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_item_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_item_t       out_data_o
);

  cfg_t cfg_q;
  logic pix_valid, pix_ready;
  pix_t pix;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= WidthRst;
      cfg_q.image_height <= HeightRst;
      cfg_q.place_x      <= '0;
      cfg_q.place_y      <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (reg_idx_e'(cfg_index_i))
        REG_WIDTH:   cfg_q.image_width  <= cfg_data_i[WidthW-1:0];
        REG_HEIGHT:  cfg_q.image_height <= cfg_data_i[HeightW-1:0];
        REG_PLACE_X: cfg_q.place_x      <= cfg_data_i[WidthW-1:0];
        REG_PLACE_Y: cfg_q.place_y      <= cfg_data_i[HeightW-1:0];
        default: ;
      endcase
    end
  end

  bmp24fb_parse #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .pix_valid_o (pix_valid),
    .pix_ready_i (pix_ready),
    .pix_o       (pix)
  );

  bmp24fb_index #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_index (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pix_valid_i (pix_valid),
    .pix_ready_o (pix_ready),
    .pix_i       (pix),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/bmp24fb_checker.sv -----
`include "bmp24_to_framebuffer_writer_assert.svh"

module bmp24fb_checker import bmp24fb_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input out_item_t       out_data_o
);

  logic in_acc, out_stall;

  assign in_acc    = in_valid_i && in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;

  // a stalled output word stays up and unchanged
  `BMP24FB_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o)
  `BMP24FB_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_stall, $stable(out_data_o))
  // a fresh output word comes from a byte taken in, via the pixel and index registers
  `BMP24FB_ASSERT_IMP(a_out_latency, clk_i, rst_ni, $rose(out_valid_o), $past(in_acc, 2))
  // oversize placement never carries a real index
  `BMP24FB_ASSERT_IMP(a_big_index, clk_i, rst_ni, out_valid_o && out_data_o.too_big,
                      out_data_o.screen_index == '0)

endmodule

bind bmp24_to_framebuffer_writer bmp24fb_checker u_checker (.*);

// ----- tb/tb_bmp24_to_framebuffer_writer.sv -----
module tb_bmp24_to_framebuffer_writer;
  import bmp24fb_pkg::*;

  localparam int unsigned RandomBytes = 380;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned HoldCycles  = 400;

  // file parser and pixel placement, one byte at a time
  class framebuffer_scoreboard;
    logic [WidthW-1:0]  img_w;
    logic [HeightW-1:0] img_h;
    logic [WidthW-1:0]  pos_x;
    logic [HeightW-1:0] pos_y;
    int unsigned header_left;
    int unsigned phase;
    int unsigned col_cnt;
    int unsigned row_cnt;
    int unsigned pad_left;
    logic [15:0] partial;
    bit          done;
    out_item_t   expected_pixels[$];
    int unsigned n_pixels;
    int unsigned n_big;
    int unsigned n_last;

    function new();
      img_w = WidthRst;
      img_h = HeightRst;
      pos_x = '0;
      pos_y = '0;
      n_pixels = 0;
      n_big = 0;
      n_last = 0;
      restart();
    endfunction

    function void restart();
      header_left = HeaderBytesDef;
      phase = 0;
      col_cnt = 0;
      row_cnt = 0;
      pad_left = 0;
      partial = '0;
      done = 1'b0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [CfgW-1:0] val);
      case (idx)
        REG_WIDTH:   img_w = val[WidthW-1:0];
        REG_HEIGHT:  img_h = val[HeightW-1:0];
        REG_PLACE_X: pos_x = val[WidthW-1:0];
        REG_PLACE_Y: pos_y = val[HeightW-1:0];
        default: ;
      endcase
    endfunction

    function void note_byte(in_item_t it);
      int unsigned w;
      int unsigned h;
      int unsigned col;
      int unsigned row;
      bit          big;
      bit          row_end;
      out_item_t   px;
      w = (img_w == 0) ? 1 : img_w;
      h = (img_h == 0) ? 1 : img_h;
      if (it.file_start) restart();
      if (done) return;
      if (header_left > 0) begin
        header_left--;
        return;
      end
      if (pad_left > 0) begin
        pad_left--;
        return;
      end
      if (phase == 0) begin
        partial = {8'h00, it.data_byte};
        phase = 1;
        return;
      end
      if (phase == 1) begin
        partial[15:8] = it.data_byte;
        phase = 2;
        return;
      end
      phase = 0;
      px.pixel_word = {it.data_byte, partial};
      partial = '0;
      // counters past a shrunk size are clamped
      col = (col_cnt < w - 1) ? col_cnt : w - 1;
      row = (row_cnt < h - 1) ? row_cnt : h - 1;
      big = (pos_x + w > ScreenWidthDef) || (pos_y + h > ScreenHeightDef);
      px.screen_index = big ? '0 :
          IndexW'((pos_y + (h - 1 - row)) * ScreenWidthDef + pos_x + col);
      row_end = (col_cnt >= w - 1);
      px.last_pixel = row_end && (row_cnt >= h - 1);
      px.too_big = big;
      if (row_end) begin
        col_cnt = 0;
        row_cnt = (row_cnt + 1) & 32'h1FF;
        pad_left = (4 - ((w * 3) & 3)) & 3;
      end else begin
        col_cnt = (col_cnt + 1) & 32'h3FF;
      end
      if (px.last_pixel) begin
        done = 1'b1;
        pad_left = 0;
        n_last++;
      end
      if (big) n_big++;
      n_pixels++;
      expected_pixels.push_back(px);
    endfunction

    function bit check_pixel(out_item_t got, output string why);
      out_item_t want;
      why = "";
      if (expected_pixels.size() == 0) begin
        why = $sformatf("unexpected word idx=%0d pix=%h", got.screen_index, got.pixel_word);
        return 1'b0;
      end
      want = expected_pixels.pop_front();
      if (got.screen_index !== want.screen_index)
        why = {why, $sformatf(" screen_index %0d/%0d", got.screen_index, want.screen_index)};
      if (got.pixel_word !== want.pixel_word)
        why = {why, $sformatf(" pixel_word %h/%h", got.pixel_word, want.pixel_word)};
      if (got.last_pixel !== want.last_pixel)
        why = {why, $sformatf(" last_pixel %b/%b", got.last_pixel, want.last_pixel)};
      if (got.too_big !== want.too_big)
        why = {why, $sformatf(" too_big %b/%b", got.too_big, want.too_big)};
      if (why != "") why = {"word mismatch (got/want):", why};
      return why == "";
    endfunction

    function int unsigned pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            cfg_valid_i;
  logic            cfg_ready_o;
  logic [1:0]      cfg_index_i;
  logic [CfgW-1:0] cfg_data_i;
  logic            in_valid_i;
  logic            in_ready_o;
  in_item_t        in_data_i;
  logic            out_valid_o;
  logic            out_ready_i;
  out_item_t       out_data_o;

  framebuffer_scoreboard sb;

  int unsigned error_count = 0;
  int unsigned sent_bytes = 0;
  int unsigned file_count = 0;
  int unsigned reg_writes = 0;
  int unsigned reconfigs = 0;
  int unsigned burst_left = 0;
  bit          hold_request = 1'b0;
  int unsigned hold_seen = 0;
  logic [WidthW-1:0]  cur_w;
  logic [HeightW-1:0] cur_h;

  bmp24_to_framebuffer_writer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    string why;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (!sb.check_pixel(out_data_o, why)) report(why);
      end
      if (in_valid_i && in_ready_o) sb.note_byte(in_data_i);
      if (cfg_valid_i && cfg_ready_o) begin
        sb.write_reg(reg_idx_e'(cfg_index_i), cfg_data_i);
        reg_writes++;
      end
    end
  end

  // receiver: changing stall pattern, plus one long hold-off on request
  initial begin
    int unsigned rx_cycle;
    int unsigned rx_mode;
    rx_cycle = 0;
    rx_mode = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      rx_cycle++;
      if (hold_request) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_seen += HoldCycles;
        hold_request = 1'b0;
      end else begin
        case (rx_mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= (rx_cycle % 5) != 0;
          default: out_ready_i <= (rx_cycle % 16) < 4;
        endcase
        if (rx_cycle % 300 == 0) rx_mode = $urandom_range(0, 3);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fs);
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{data_byte: b, file_start: fs};
    burst_left--;
    sent_bytes++;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // registers only change once the pipeline is empty
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_image(input int unsigned w, input int unsigned h,
                           input int unsigned x, input int unsigned y);
    write_reg(REG_WIDTH, CfgW'(w));
    write_reg(REG_HEIGHT, CfgW'(h));
    write_reg(REG_PLACE_X, CfgW'(x));
    write_reg(REG_PLACE_Y, CfgW'(y));
    cur_w = WidthW'(w);
    cur_h = HeightW'(h);
  endtask

  function automatic int unsigned file_bytes(input int unsigned w, input int unsigned h);
    int unsigned we;
    int unsigned he;
    we = (w == 0) ? 1 : w;
    he = (h == 0) ? 1 : h;
    return HeaderBytesDef + he * (we * 3 + ((4 - ((we * 3) & 3)) & 3));
  endfunction

  task automatic pick_config();
    int unsigned w;
    int unsigned h;
    int unsigned we;
    int unsigned he;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    w = $urandom_range(0, 9);
    h = $urandom_range(0, 6);
    we = (w == 0) ? 1 : w;
    he = (h == 0) ? 1 : h;
    case (sel)
      6: set_image(w, h, ScreenWidthDef - we, ScreenHeightDef - he);
      7: begin
        w = $urandom_range(2, 9);
        set_image(w, h, $urandom_range(ScreenWidthDef - w + 1, ScreenWidthDef - 1),
                  $urandom_range(0, ScreenHeightDef - he));
      end
      // raw place values and a height whose unused top bit may be set
      8: set_image(w, ($urandom_range(0, 1) << 9) | h, 10'($urandom), 10'($urandom));
      9: set_image($urandom_range(20, 60), $urandom_range(1, 2),
                   $urandom_range(0, 700), $urandom_range(0, 470));
      default: set_image(w, h, $urandom_range(0, ScreenWidthDef - we),
                         $urandom_range(0, ScreenHeightDef - he));
    endcase
  endtask

  // reconf_at < 0: no register change inside the file
  task automatic send_file(input int unsigned len, input logic first_fs,
                           input int reconf_at);
    for (int i = 0; i < int'(len); i++) begin
      if (i == reconf_at) begin
        drain();
        pick_config();
        reconfigs++;
      end
      send_byte(8'($urandom), (i == 0) ? first_fs : 1'b0);
    end
    file_count++;
  endtask

  task automatic send_junk(input int unsigned n);
    repeat (n) send_byte(8'($urandom), 1'b0);
  endtask

  initial begin
    int unsigned random_bytes;
    int unsigned len;
    int unsigned mode;
    int unsigned n;
    int          at;
    bit          pressure_done;
    sb = new();
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_WIDTH;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cur_w = WidthRst;
    cur_h = HeightRst;
    random_bytes = 0;
    pressure_done = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset size, first file without a start flag, cut off after a few pixels
    send_file(HeaderBytesDef + 12, 1'b0, -1);
    // new file inside the header
    send_file(20, 1'b1, -1);
    drain();
    set_image(1, 1, 0, 0);
    send_file(file_bytes(1, 1), 1'b1, -1);
    send_junk(5);
    // zero size acts as 1x1, placed on the last screen pixel
    drain();
    set_image(0, 0, ScreenWidthDef - 1, ScreenHeightDef - 1);
    send_file(file_bytes(0, 0), 1'b1, -1);
    drain();
    set_image(2, 2, ScreenWidthDef - 1, 0);
    send_file(file_bytes(2, 2), 1'b1, -1);
    drain();
    set_image(3, 2, 0, ScreenHeightDef - 1);
    send_file(file_bytes(3, 2), 1'b1, -1);
    for (int w = 4; w <= 5; w++) begin
      drain();
      set_image(w, 3, $urandom_range(0, 700), $urandom_range(0, 400));
      send_file(file_bytes(w, 3), 1'b1, -1);
    end
    // one wide row
    drain();
    set_image(24, 1, 0, 0);
    send_file(file_bytes(24, 1), 1'b1, -1);
    // full height and all-ones sizes, cut short
    drain();
    set_image(1, ScreenHeightDef, 0, 0);
    send_file(HeaderBytesDef + 30, 1'b1, -1);
    drain();
    set_image(10'h3FF, 10'h1FF, 1, 1);
    send_file(HeaderBytesDef + 15, 1'b1, -1);
    drain();
    set_image(ScreenWidthDef, ScreenHeightDef, 1, 0);
    send_file(HeaderBytesDef + 9, 1'b1, -1);
    // height data with bit 9 set is masked down to 3
    drain();
    set_image(2, 10'h203, 10'h3FF, 10'h3FF);
    send_file(file_bytes(2, 3), 1'b1, -1);
    // shrink the image mid-row: counters end up past the new bounds
    drain();
    set_image(6, 3, 100, 100);
    send_file(80, 1'b1, -1);
    drain();
    set_image(2, 1, 10, 10);
    reconfigs++;
    send_junk(34);

    while (random_bytes < RandomBytes) begin
      drain();
      if (!pressure_done) begin
        // long output stall while bytes keep coming
        set_image(9, 6, $urandom_range(0, 700), $urandom_range(0, 400));
        hold_request = 1'b1;
        pressure_done = 1'b1;
        burst_left = 1000;
        len = file_bytes(cur_w, cur_h);
        send_file(len, 1'b1, -1);
        random_bytes += len;
        continue;
      end
      pick_config();
      len = file_bytes(cur_w, cur_h);
      mode = $urandom_range(0, 19);
      if (mode < 15) begin
        at = ($urandom_range(0, 9) == 0) ? $urandom_range(HeaderBytesDef, len - 1) : -1;
        send_file(len, 1'b1, at);
        send_junk($urandom_range(0, 4));
        random_bytes += len;
      end else if (mode < 18) begin
        n = $urandom_range(1, len - 1);
        send_file(n, 1'b1, -1);
        random_bytes += n;
      end else begin
        n = $urandom_range(10, 60);
        send_byte(8'($urandom), 1'b1);
        for (int i = 1; i < int'(n); i++)
          send_byte(8'($urandom), $urandom_range(0, 15) == 0);
        file_count++;
        random_bytes += n;
      end
    end

    drain();
    $display("run: %0d files, %0d bytes, %0d pixel words (%0d too big, %0d image ends)",
             file_count, sent_bytes, sb.n_pixels, sb.n_big, sb.n_last);
    $display("run: %0d register writes, %0d mid-image resizes, %0d cycles of output hold",
             reg_writes, reconfigs, hold_seen);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d words still expected", sb.pending());
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- bmp24_to_framebuffer_writer.f -----
+incdir+rtl
rtl/bmp24fb_pkg.sv
rtl/bmp24fb_parse.sv
rtl/bmp24fb_index.sv
rtl/bmp24_to_framebuffer_writer.sv
rtl/bmp24fb_checker.sv
tb/tb_bmp24_to_framebuffer_writer.sv
